@@ hw/rtl/absolute_loader_block_deframer_top_macros.svh @@
// Assertion macros shared by the deframer checker.
`ifndef ABSOLUTE_LOADER_BLOCK_DEFRAMER_TOP_MACROS_SVH
`define ABSOLUTE_LOADER_BLOCK_DEFRAMER_TOP_MACROS_SVH

// Check a property at every rising clock edge, reset included.
`define ABLD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property only while out of reset.
`define ABLD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hw/rtl/abld_pkg.sv @@
// Types and constants of the absolute loader block deframer.
package abld_pkg;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_HDR_HI = 4'd1,
    PH_CNT_LO = 4'd2,
    PH_CNT_HI = 4'd3,
    PH_ADR_LO = 4'd4,
    PH_ADR_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CHECK  = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_END        = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_BAD_SUM    = 2'd3
  } kind_e;

  localparam logic [15:0] HeaderWord  = 16'h0001;
  localparam logic [15:0] HeaderBytes = 16'd6;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic        start_given;
  } result_t;

endpackage

@@ hw/rtl/abld_in_reg.sv @@
// Input register: holds one byte item until the deframer core takes it.
module abld_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_value_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ hw/rtl/abld_core.sv @@
// Block framing state machine: header, count, address, data and checksum.
module abld_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output abld_pkg::result_t    res_o
);

  abld_pkg::phase_e phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] left_q, left_d;
  logic [15:0] load_addr_q, load_addr_d;
  logic [15:0] wr_addr_q, wr_addr_d;
  logic [7:0]  low_q, low_d;

  logic [7:0]  sum_add;
  logic [15:0] word;

  assign sum_add = sum_q + byte_i;
  assign word    = {byte_i, low_q};

  // Next state.
  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    left_d      = left_q;
    load_addr_d = load_addr_q;
    wr_addr_d   = wr_addr_q;
    low_d       = low_q;
    unique case (phase_q)
      abld_pkg::PH_HDR_HI: begin
        sum_d   = sum_add;
        phase_d = (word != abld_pkg::HeaderWord) ? abld_pkg::PH_HUNT : abld_pkg::PH_CNT_LO;
      end
      abld_pkg::PH_CNT_LO: begin
        sum_d   = sum_add;
        low_d   = byte_i;
        phase_d = abld_pkg::PH_CNT_HI;
      end
      abld_pkg::PH_ADR_LO: begin
        sum_d   = sum_add;
        low_d   = byte_i;
        phase_d = abld_pkg::PH_ADR_HI;
      end
      abld_pkg::PH_CNT_HI: begin
        sum_d = sum_add;
        if (word < abld_pkg::HeaderBytes) begin
          phase_d = abld_pkg::PH_HUNT;
        end else begin
          left_d  = word - abld_pkg::HeaderBytes;
          phase_d = abld_pkg::PH_ADR_LO;
        end
      end
      abld_pkg::PH_ADR_HI: begin
        sum_d       = sum_add;
        load_addr_d = word;
        wr_addr_d   = word;
        phase_d     = (left_q == 16'd0) ? abld_pkg::PH_HUNT : abld_pkg::PH_DATA;
      end
      abld_pkg::PH_DATA: begin
        sum_d     = sum_add;
        wr_addr_d = wr_addr_q + 16'd1;
        left_d    = left_q - 16'd1;
        if (left_q == 16'd1) begin
          phase_d = abld_pkg::PH_CHECK;
        end
      end
      abld_pkg::PH_CHECK: begin
        sum_d   = sum_add;
        phase_d = abld_pkg::PH_HUNT;
      end
      default: begin
        // hunt: skip leader zeros, a nonzero byte opens a block
        if (byte_i != 8'd0) begin
          sum_d   = byte_i;
          low_d   = byte_i;
          phase_d = abld_pkg::PH_HDR_HI;
        end else begin
          phase_d = abld_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.kind        = abld_pkg::KIND_DATA;
    res_o.address     = word;
    res_o.data_byte   = 8'd0;
    res_o.start_given = 1'b0;
    unique case (phase_q)
      abld_pkg::PH_HDR_HI: begin
        res_valid_o = (word != abld_pkg::HeaderWord);
        res_o.kind  = abld_pkg::KIND_BAD_HEADER;
      end
      abld_pkg::PH_CNT_HI: begin
        res_valid_o = (word < abld_pkg::HeaderBytes);
        res_o.kind  = abld_pkg::KIND_BAD_HEADER;
      end
      abld_pkg::PH_ADR_HI: begin
        res_valid_o       = (left_q == 16'd0);
        res_o.kind        = abld_pkg::KIND_END;
        res_o.start_given = !word[0];
      end
      abld_pkg::PH_DATA: begin
        res_valid_o     = 1'b1;
        res_o.address   = wr_addr_q;
        res_o.data_byte = byte_i;
      end
      abld_pkg::PH_CHECK: begin
        res_valid_o     = (sum_add != 8'd0);
        res_o.kind      = abld_pkg::KIND_BAD_SUM;
        res_o.address   = load_addr_q;
        res_o.data_byte = byte_i;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= abld_pkg::PH_HUNT;
      sum_q       <= 8'd0;
      left_q      <= 16'd0;
      load_addr_q <= 16'd0;
      wr_addr_q   <= 16'd0;
      low_q       <= 8'd0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      left_q      <= left_d;
      load_addr_q <= load_addr_d;
      wr_addr_q   <= wr_addr_d;
      low_q       <= low_d;
    end
  end

endmodule

@@ hw/rtl/abld_out_reg.sv @@
// Result register: holds one result item until the consumer takes it.
module abld_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  abld_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output abld_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  abld_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ hw/rtl/absolute_loader_block_deframer_top.sv @@
// Absolute loader block deframer: takes one image byte per item and gives
// data writes, load end and error items. Throughput is one byte per clock
// cycle while no result item is held by the consumer; a byte's result item,
// if any, passes through the input register, then framing logic into the
// result register. A result item held by the consumer stalls the framing
// logic, and in_ready_o follows out_ready_i combinationally while both
// registers are full. Leader zeros, a good checksum and the header bytes of a
// well-formed data block give no result item.
module absolute_loader_block_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic        start_given_o
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              fire;
  logic              slot_free;
  logic              res_valid;
  abld_pkg::result_t res;
  abld_pkg::result_t out_res;

  // advance when the result slot can take whatever this byte produces
  assign fire = byte_valid && slot_free;

  abld_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_value_i(byte_value_i),
    .take_i      (fire),
    .valid_o     (byte_valid),
    .byte_o      (byte_q)
  );

  abld_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  abld_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && res_valid),
    .res_i      (res),
    .free_o     (slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign address_o     = out_res.address;
  assign data_byte_o   = out_res.data_byte;
  assign start_given_o = out_res.start_given;

endmodule

@@ hw/rtl/abld_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
`include "absolute_loader_block_deframer_top_macros.svh"

module abld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [15:0] address_o,
  input logic [7:0]  data_byte_o,
  input logic        start_given_o
);

  `ABLD_ASSERT_ALWAYS(a_no_item_in_reset, clk_i,
                      !rst_ni |-> !out_valid_o,
                      "result item during reset")
  `ABLD_ASSERT_RUN(a_out_hold, clk_i, rst_ni,
                   out_valid_o && !out_ready_i |=> out_valid_o,
                   "result item dropped while stalled")
  `ABLD_ASSERT_RUN(a_out_stable, clk_i, rst_ni,
                   out_valid_o && !out_ready_i |=> $stable(address_o) &&
                   $stable(data_byte_o) && $stable(result_kind_o),
                   "stalled result item changed")
  `ABLD_ASSERT_RUN(a_start_only_end, clk_i, rst_ni,
                   out_valid_o && start_given_o |-> result_kind_o == abld_pkg::KIND_END,
                   "start flag on a non-end item")
  `ABLD_ASSERT_RUN(a_no_data_end_hdr, clk_i, rst_ni,
                   out_valid_o && (result_kind_o == abld_pkg::KIND_END ||
                   result_kind_o == abld_pkg::KIND_BAD_HEADER) |-> data_byte_o == 8'd0,
                   "data byte set on end or header item")

endmodule

bind absolute_loader_block_deframer_top abld_checker u_abld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_kind_o(result_kind_o),
  .address_o    (address_o),
  .data_byte_o  (data_byte_o),
  .start_given_o(start_given_o)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the absolute loader block deframer top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 420;
  localparam int BusyPct     = 24;
  localparam int DrainCycles = 10;
  localparam abld_pkg::result_t NoResult = '{abld_pkg::KIND_DATA, 16'h0000, 8'h00, 1'b0};

  typedef struct packed {
    logic [7:0]        value;
    logic              typed;
    logic              gives;
    abld_pkg::result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [15:0] address_o;
  logic [7:0]  data_byte_o;
  logic        start_given_o;

  // Typed expectation riding along with the item on the input side.
  logic              row_typed = 1'b0;
  logic              row_gives = 1'b0;
  abld_pkg::result_t row_expect = NoResult;

  int idle_pct = BusyPct;
  int bytes_sent = 0;
  int mismatch_count = 0;
  abld_pkg::result_t pending_results[$];

  // Deframer state as seen by the predictor.
  abld_pkg::phase_e fr_phase = abld_pkg::PH_HUNT;
  logic [7:0]  block_sum = 8'h00;
  logic [15:0] data_left = 16'h0000;
  logic [15:0] block_addr = 16'h0000;
  logic [15:0] next_addr = 16'h0000;
  logic [7:0]  low_hold = 8'h00;

  stim_row_t directed_rows [30] = '{
    '{8'h00, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b0, NoResult},
    '{8'hFF, 1'b1, 1'b1, '{abld_pkg::KIND_BAD_HEADER, 16'hFFFF, 8'h00, 1'b0}},
    '{8'h01, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h05, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b1, '{abld_pkg::KIND_BAD_HEADER, 16'h0005, 8'h00, 1'b0}},
    '{8'h01, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h08, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'hAA, 1'b1, 1'b1, '{abld_pkg::KIND_DATA, 16'hFFFF, 8'hAA, 1'b0}},
    '{8'h55, 1'b1, 1'b1, '{abld_pkg::KIND_DATA, 16'h0000, 8'h55, 1'b0}},
    '{8'hFA, 1'b0, 1'b0, NoResult},
    '{8'h01, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h07, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h34, 1'b0, 1'b0, NoResult},
    '{8'h12, 1'b0, 1'b0, NoResult},
    '{8'h80, 1'b1, 1'b1, '{abld_pkg::KIND_DATA, 16'h1234, 8'h80, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{abld_pkg::KIND_BAD_SUM, 16'h1234, 8'h00, 1'b0}},
    '{8'h01, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h06, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h02, 1'b1, 1'b1, '{abld_pkg::KIND_END, 16'h0200, 8'h00, 1'b1}}
  };

  absolute_loader_block_deframer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .address_o    (address_o),
    .data_byte_o  (data_byte_o),
    .start_given_o(start_given_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the framing state by one byte and return the item it causes.
  task automatic frame_byte(input logic [7:0] b, output bit gives,
                            output abld_pkg::result_t res);
    logic [15:0] word;
    word = {b, low_hold};
    gives = 1'b0;
    res = NoResult;
    case (fr_phase)
      abld_pkg::PH_HDR_HI: begin
        block_sum = block_sum + b;
        if (word != abld_pkg::HeaderWord) begin
          fr_phase = abld_pkg::PH_HUNT;
          gives = 1'b1;
          res = '{abld_pkg::KIND_BAD_HEADER, word, 8'h00, 1'b0};
        end else begin
          fr_phase = abld_pkg::PH_CNT_LO;
        end
      end
      abld_pkg::PH_CNT_LO: begin
        block_sum = block_sum + b;
        low_hold = b;
        fr_phase = abld_pkg::PH_CNT_HI;
      end
      abld_pkg::PH_CNT_HI: begin
        block_sum = block_sum + b;
        if (word < abld_pkg::HeaderBytes) begin
          fr_phase = abld_pkg::PH_HUNT;
          gives = 1'b1;
          res = '{abld_pkg::KIND_BAD_HEADER, word, 8'h00, 1'b0};
        end else begin
          data_left = word - abld_pkg::HeaderBytes;
          fr_phase = abld_pkg::PH_ADR_LO;
        end
      end
      abld_pkg::PH_ADR_LO: begin
        block_sum = block_sum + b;
        low_hold = b;
        fr_phase = abld_pkg::PH_ADR_HI;
      end
      abld_pkg::PH_ADR_HI: begin
        block_sum = block_sum + b;
        block_addr = word;
        next_addr = word;
        if (data_left == 16'h0000) begin
          fr_phase = abld_pkg::PH_HUNT;
          gives = 1'b1;
          res = '{abld_pkg::KIND_END, word, 8'h00, ~word[0]};
        end else begin
          fr_phase = abld_pkg::PH_DATA;
        end
      end
      abld_pkg::PH_DATA: begin
        block_sum = block_sum + b;
        gives = 1'b1;
        res = '{abld_pkg::KIND_DATA, next_addr, b, 1'b0};
        next_addr = next_addr + 16'd1;
        data_left = data_left - 16'd1;
        if (data_left == 16'h0000) fr_phase = abld_pkg::PH_CHECK;
      end
      abld_pkg::PH_CHECK: begin
        block_sum = block_sum + b;
        fr_phase = abld_pkg::PH_HUNT;
        if (block_sum != 8'h00) begin
          gives = 1'b1;
          res = '{abld_pkg::KIND_BAD_SUM, block_addr, b, 1'b0};
        end
      end
      default: begin
        // Leader zeros are skipped; anything else opens a header.
        if (b != 8'h00) begin
          block_sum = b;
          low_hold = b;
          fr_phase = abld_pkg::PH_HDR_HI;
        end
      end
    endcase
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0d ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    abld_pkg::result_t want;
    abld_pkg::result_t predicted;
    bit gives;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0d ns: unexpected item, expected none, got kind %0d addr %h data %h",
                   $time, result_kind_o, address_o, data_byte_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("result_kind", 16'(want.kind), 16'(result_kind_o));
          report_field("address", want.address, address_o);
          report_field("data_byte", 16'(want.data_byte), 16'(data_byte_o));
          report_field("start_given", 16'(want.start_given), 16'(start_given_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        frame_byte(byte_value_i, gives, predicted);
        if (row_typed) begin
          gives = row_gives;
          predicted = row_expect;
        end
        if (gives) pending_results.push_back(predicted);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // Starts and ends at a falling edge; holds the item until it is taken.
  task automatic put_byte(input logic [7:0] v, input logic typed, input logic gives,
                          input abld_pkg::result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= v;
    row_typed <= typed;
    row_gives <= gives;
    row_expect <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put_plain(input logic [7:0] v);
    put_byte(v, 1'b0, 1'b0, NoResult);
    bytes_sent++;
  endtask

  task automatic put_block(input int n_data, input logic [15:0] addr, input bit good_sum);
    logic [15:0] count;
    logic [7:0]  sum;
    logic [7:0]  v;
    count = 16'(n_data) + abld_pkg::HeaderBytes;
    sum = 8'h01 + count[7:0] + count[15:8] + addr[7:0] + addr[15:8];
    put_plain(8'h01);
    put_plain(8'h00);
    put_plain(count[7:0]);
    put_plain(count[15:8]);
    put_plain(addr[7:0]);
    put_plain(addr[15:8]);
    for (int i = 0; i < n_data; i++) begin
      v = 8'($urandom);
      sum = sum + v;
      put_plain(v);
    end
    if (n_data != 0) put_plain(good_sum ? 8'(-sum) : 8'($urandom));
  endtask

  initial begin : stimulus
    int pick;
    int n_data;
    logic [15:0] addr;
    logic [7:0] lo;
    logic [7:0] hi;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      put_byte(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].gives,
               directed_rows[i].res);
    end

    bytes_sent = 0;
    while (bytes_sent < RandomItems) begin
      // Keep both sides busy through one long stretch.
      idle_pct = (bytes_sent >= 150 && bytes_sent < 250) ? 0 : BusyPct;
      pick = $urandom_range(99);
      n_data = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      addr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(7)) : 16'($urandom);
      if (pick < 8) begin
        repeat ($urandom_range(4, 1)) put_byte(8'h00, 1'b0, 1'b0, NoResult);
      end else if (pick < 18) begin
        lo = 8'($urandom_range(255, 1));
        hi = 8'($urandom);
        if ({hi, lo} == abld_pkg::HeaderWord) hi = 8'h80;
        put_plain(lo);
        put_plain(hi);
      end else if (pick < 24) begin
        put_plain(8'h01);
        put_plain(8'h00);
        put_plain(8'($urandom_range(5)));
        put_plain(8'h00);
      end else if (pick < 32) begin
        put_block(0, 16'($urandom), 1'b1);
      end else if (pick < 42) begin
        put_block(n_data, addr, 1'b0);
      end else begin
        put_block(n_data, addr, 1'b1);
      end
    end
    in_valid_i <= 1'b0;
    idle_pct = BusyPct;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("absolute_loader_block_deframer_top regression: pass");
    end else begin
      $display("absolute_loader_block_deframer_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("absolute_loader_block_deframer_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/abld_pkg.sv
hw/rtl/abld_in_reg.sv
hw/rtl/abld_core.sv
hw/rtl/abld_out_reg.sv
hw/rtl/absolute_loader_block_deframer_top.sv
hw/rtl/abld_checker.sv
bench/testbench.sv
